FILE: src/bhp_pkg.sv
// shared types, codes and constants of the ball height pid fan drive core
package bhp_pkg;

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int TICK_W    = 10;
  localparam int WORD_W    = 16;
  localparam int ECHO_W    = 16;
  localparam int DUTY_W    = 10;
  localparam int TOTAL_W   = 31;
  localparam int TERM_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PGAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DGAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK  = 3'd3;

  localparam logic [CFG_W-1:0]  PGAIN_RST = 48'd419430400;
  localparam logic [CFG_W-1:0]  IGAIN_RST = 48'd1678;
  localparam logic [CFG_W-1:0]  DGAIN_RST = 48'd83886080000;
  localparam logic [TICK_W-1:0] TICK_RST  = 10'd23;

  localparam logic [11:0]        V_BLANK      = 12'hFFF;
  localparam logic [11:0]        SP_ZERO      = 12'd1735;
  localparam logic [15:0]        ECHO_LIMIT   = 16'd18500;
  localparam logic signed [31:0] ERR_OFFSET   = 32'sd5570560;
  localparam logic [TOTAL_W-1:0] PWM_FULL     = 31'd6547200;
  localparam logic [12:0]        PWM_RECIP    = 13'd5243;
  localparam logic [DUTY_W-1:0]  DUTY_MAX     = 10'd1023;

  // 18 * 65536 / 347 scaled by 2^20, and 17 * 65536 / 1000 scaled by 2^22, rounded up
  localparam logic [31:0] SP_RECIP   = 32'd3564699082;
  localparam logic [32:0] DIST_RECIP = 33'd4672924419;

  localparam int DIV_W     = 36;
  localparam int DVS_W     = 10;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] PART_HH = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LH = 2'd2;
  localparam logic [1:0] PART_LL = 2'd3;

  localparam logic [2:0] STEP_LAST_MUL = 3'd3;
  localparam logic [2:0] STEP_LAST_ACC = 3'd4;
  localparam logic [2:0] STEP_FIN      = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ERR,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_TERM,
    ST_SUM,
    ST_DONE
  } bhp_state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      scale_calc;
    logic      div_start;
    logic      err_calc;
    logic      acc_mul;
    logic      acc_add;
    logic      term_mul;
    logic      term_acc;
    logic      term_fin;
    term_sel_t term_sel;
    logic [1:0] term_part;
    logic      sum_calc;
    logic      out_load;
  } bhp_cmd_t;

  typedef struct packed {
    logic div_done;
  } bhp_sts_t;

endpackage

FILE: src/bhp_if.sv
// word channels of the ball height pid fan drive core
interface bhp_in_if import bhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] converter_word;
  logic [ECHO_W-1:0] echo_width_us;

  modport source (output valid, converter_word, echo_width_us, input ready);
  modport sink   (input valid, converter_word, echo_width_us, output ready);
endinterface

interface bhp_out_if import bhp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DUTY_W-1:0]        pwm_duty;
  logic [TOTAL_W-1:0]       total_drive;
  logic signed [TERM_W-1:0] proportional_term;
  logic signed [TERM_W-1:0] integral_term;
  logic signed [TERM_W-1:0] derivative_term;

  modport source (output valid, pwm_duty, total_drive, proportional_term, integral_term,
                  derivative_term, input ready);
  modport sink   (input valid, pwm_duty, total_drive, proportional_term, integral_term,
                  derivative_term, output ready);
endinterface

FILE: src/bhp_div.sv
// iterative unsigned divider, two quotient bits per cycle
module bhp_div import bhp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DVS_W:0]       trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_nxt, quo_nxt[DIV_W-1]};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_nxt[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/bhp_datapath.sv
// datapath: configuration, height and setpoint, error state, pid terms and result register
module bhp_datapath import bhp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [WORD_W-1:0]        converter_word,
  input  logic [ECHO_W-1:0]        echo_width_us,
  input  bhp_cmd_t                 cmd,
  output bhp_sts_t                 sts,
  output logic [DUTY_W-1:0]        pwm_duty,
  output logic [TOTAL_W-1:0]       total_drive,
  output logic signed [TERM_W-1:0] proportional_term,
  output logic signed [TERM_W-1:0] integral_term,
  output logic signed [TERM_W-1:0] derivative_term
);

  logic [CFG_W-1:0]  pgain_r, igain_r, dgain_r;
  logic [TICK_W-1:0] tick_r;
  logic [TICK_W-1:0] ivl;

  logic [11:0]        v_r;
  logic [14:0]        e_r;
  logic [22:0]        sp_r;
  logic [24:0]        dist_r;
  logic signed [31:0] err_r;
  logic signed [31:0] prev_r;
  logic signed [47:0] acc_r;
  logic signed [42:0] eprod_r;
  logic               rate_neg_r;
  logic [32:0]        rate_mag_r;
  logic [32:0]        rate_q_r;

  logic [47:0]        prod_r;
  logic [1:0]         prod_part_r;
  logic [55:0]        tsum_r;
  logic               tsat_r;
  logic signed [TERM_W-1:0] p_r, i_r, d_r;
  logic [TOTAL_W-1:0] total_r;

  logic [DUTY_W-1:0]        duty_o_r;
  logic [TOTAL_W-1:0]       total_o_r;
  logic signed [TERM_W-1:0] p_o_r, i_o_r, d_o_r;

  logic [15:0]      swapped;
  logic [11:0]      v_raw;
  logic [10:0]      sp_diff;
  logic [42:0]      sp_prod;
  logic [47:0]      dist_prod;
  logic [DIV_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [DIV_W-1:0] quo;

  logic [32:0]        diff;
  logic signed [48:0] acc_sum;

  logic [CFG_W-1:0] tgain;
  logic [47:0]      tx;
  logic [47:0]      tmag;
  logic             tneg;
  logic [23:0]      ma, mb;
  logic [55:0]      lim;
  logic [55:0]      tval;
  logic [31:0]      tv32;
  logic [31:0]      tres;

  logic signed [33:0] tot_sum;
  logic [27:0]        duty_prod;
  logic [DUTY_W-1:0]  duty;

  assign ivl = (tick_r == '0) ? TICK_W'(1) : tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pgain_r <= PGAIN_RST;
      igain_r <= IGAIN_RST;
      dgain_r <= DGAIN_RST;
      tick_r  <= TICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PGAIN: pgain_r <= cfg_wdata;
        CFG_IGAIN: igain_r <= cfg_wdata;
        CFG_DGAIN: dgain_r <= cfg_wdata;
        CFG_TICK:  tick_r  <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input conditioning
  assign swapped = {converter_word[7:0], converter_word[15:8]};
  assign v_raw   = swapped[15:4];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r <= (v_raw == V_BLANK) ? 12'd0 : v_raw;
      e_r <= (echo_width_us > ECHO_LIMIT) ? ECHO_LIMIT[14:0] : echo_width_us[14:0];
    end
  end

  // setpoint and distance by reciprocal multiplication
  assign sp_diff   = 11'(SP_ZERO - v_r);
  assign sp_prod   = {32'd0, sp_diff} * {11'd0, SP_RECIP};
  assign dist_prod = {33'd0, e_r} * {15'd0, DIST_RECIP};

  always_ff @(posedge clk) begin
    if (cmd.scale_calc) begin
      sp_r   <= (v_r < SP_ZERO) ? sp_prod[42:20] : '0;
      dist_r <= dist_prod[46:22];
    end
  end

  // rate divider operands
  assign dvd = {3'd0, rate_mag_r};
  assign dvs = ivl;

  bhp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (div_done) begin
      rate_q_r <= quo[32:0];
    end
  end

  // error, integral and rate dividend
  assign diff    = {err_r[31], err_r} - {prev_r[31], prev_r};
  assign acc_sum = {acc_r[47], acc_r} + {{6{eprod_r[42]}}, eprod_r};

  always_ff @(posedge clk) begin
    if (cmd.err_calc) begin
      err_r <= $signed({9'd0, sp_r}) + $signed({7'd0, dist_r}) - ERR_OFFSET;
    end
    if (cmd.acc_mul) begin
      eprod_r    <= err_r * $signed({1'b0, ivl});
      rate_neg_r <= diff[32];
      rate_mag_r <= diff[32] ? 33'(-diff) : diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.acc_mul) begin
        prev_r <= err_r;
      end
      if (cmd.acc_add) begin
        if (acc_sum[48] != acc_sum[47]) begin
          acc_r <= acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
          acc_r <= acc_sum[47:0];
        end
      end
    end
  end

  // gain times operand, one 24x24 partial product per cycle
  always_comb begin
    tgain = pgain_r;
    tx    = {{16{err_r[31]}}, err_r};
    tneg  = err_r[31];
    tmag  = '0;
    unique case (cmd.term_sel)
      TERM_P: begin
        tgain = pgain_r;
        tx    = {{16{err_r[31]}}, err_r};
        tneg  = err_r[31];
      end
      TERM_I: begin
        tgain = igain_r;
        tx    = acc_r;
        tneg  = acc_r[47];
      end
      TERM_D: begin
        tgain = dgain_r;
        tx    = {15'd0, rate_q_r};
        tneg  = rate_neg_r;
      end
      default: begin
        tgain = dgain_r;
        tx    = {15'd0, rate_q_r};
        tneg  = rate_neg_r;
      end
    endcase
    if (cmd.term_sel == TERM_D) begin
      tmag = tx;
    end else begin
      tmag = tneg ? 48'(-tx) : tx;
    end
  end

  always_comb begin
    ma = tgain[47:24];
    mb = tmag[47:24];
    unique case (cmd.term_part)
      PART_HH: begin
        ma = tgain[47:24];
        mb = tmag[47:24];
      end
      PART_HL: begin
        ma = tgain[47:24];
        mb = tmag[23:0];
      end
      PART_LH: begin
        ma = tgain[23:0];
        mb = tmag[47:24];
      end
      PART_LL: begin
        ma = tgain[23:0];
        mb = tmag[23:0];
      end
      default: ;
    endcase
  end

  assign lim  = tneg ? 56'h0000_0080_000000 : 56'h0000_007F_FFFFFF;
  assign tval = (tsat_r || (tsum_r > lim)) ? lim : tsum_r;
  assign tv32 = tval[31:0];
  assign tres = tneg ? (~tv32 + 32'd1) : tv32;

  always_ff @(posedge clk) begin
    if (cmd.term_mul) begin
      prod_r      <= ma * mb;
      prod_part_r <= cmd.term_part;
    end
    if (cmd.term_acc) begin
      unique case (prod_part_r)
        PART_HH: begin
          tsat_r <= |prod_r[47:31];
          tsum_r <= {1'b0, prod_r[30:0], 24'd0};
        end
        PART_HL, PART_LH: tsum_r <= tsum_r + {8'd0, prod_r};
        PART_LL:          tsum_r <= tsum_r + {32'd0, prod_r[47:24]};
        default: ;
      endcase
    end
    if (cmd.term_fin) begin
      unique case (cmd.term_sel)
        TERM_P:  p_r <= $signed(tres);
        TERM_I:  i_r <= $signed(tres);
        TERM_D:  d_r <= $signed(tres);
        default: ;
      endcase
    end
  end

  // clamped total and duty
  assign tot_sum = 34'(p_r) + 34'(i_r) + 34'(d_r);

  always_ff @(posedge clk) begin
    if (cmd.sum_calc) begin
      if (tot_sum[33]) begin
        total_r <= '0;
      end else if (|tot_sum[32:31]) begin
        total_r <= {TOTAL_W{1'b1}};
      end else begin
        total_r <= tot_sum[30:0];
      end
    end
  end

  assign duty_prod = 28'(total_r[22:8] * PWM_RECIP);
  assign duty      = (total_r >= PWM_FULL) ? DUTY_MAX : duty_prod[26:17];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      duty_o_r  <= duty;
      total_o_r <= total_r;
      p_o_r     <= p_r;
      i_o_r     <= i_r;
      d_o_r     <= d_r;
    end
  end

  assign pwm_duty          = duty_o_r;
  assign total_drive       = total_o_r;
  assign proportional_term = p_o_r;
  assign integral_term     = i_o_r;
  assign derivative_term   = d_o_r;

endmodule

FILE: src/bhp_ctrl.sv
// controller: sequences one word through the datapath and owns the handshakes
module bhp_ctrl import bhp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output bhp_cmd_t cmd,
  input  bhp_sts_t sts
);

  bhp_state_t state_r, state_nxt;
  term_sel_t  term_r, term_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_r      <= TERM_P;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.term_sel  = term_r;
    cmd.term_part = step_r[1:0];
    in_ready  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale_calc = 1'b1;
        state_nxt      = ST_ERR;
      end
      ST_ERR: begin
        cmd.err_calc = 1'b1;
        state_nxt    = ST_ACC_MUL;
      end
      ST_ACC_MUL: begin
        cmd.acc_mul = 1'b1;
        state_nxt   = ST_ACC_ADD;
      end
      ST_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_RATE_GO;
      end
      ST_RATE_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (sts.div_done) begin
          term_nxt  = TERM_P;
          step_nxt  = '0;
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.term_mul = (step_r <= STEP_LAST_MUL);
        cmd.term_acc = (step_r != '0) && (step_r <= STEP_LAST_ACC);
        cmd.term_fin = (step_r == STEP_FIN);
        if (step_r == STEP_FIN) begin
          step_nxt = '0;
          unique case (term_r)
            TERM_P:  term_nxt = TERM_I;
            TERM_I:  term_nxt = TERM_D;
            TERM_D: begin
              term_nxt  = TERM_P;
              state_nxt = ST_SUM;
            end
            default: begin
              term_nxt  = TERM_P;
              state_nxt = ST_SUM;
            end
          endcase
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_SUM: begin
        cmd.sum_calc = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/ball_height_pid_fan_drive_core.sv
// top level of the ball height pid fan drive core
//
//   port      | dir | role
//   ----------+-----+----------------------------------------------------
//   in_ch     | in  | converter word and echo width, valid/ready
//   out_ch    | out | duty, clamped total and p, i, d terms, valid/ready
//   cfg_*     | in  | register write: enable, index, 48-bit data
//
// one word passes through: take, reciprocal scaling, error and integral,
// rate division on the 2-bit-per-cycle divider and the 24x24 gain multiplier for the p, i and d terms
// a new word is taken while the result waits
// a stalled result holds the sequencer in its last state until the result register frees
// synchronous reset clears control, gains to their defaults, integral and last error to zero
module ball_height_pid_fan_drive_core import bhp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bhp_in_if.sink               in_ch,
  bhp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  bhp_cmd_t cmd;
  bhp_sts_t sts;

  bhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  bhp_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .converter_word    (in_ch.converter_word),
    .echo_width_us     (in_ch.echo_width_us),
    .cmd               (cmd),
    .sts               (sts),
    .pwm_duty          (out_ch.pwm_duty),
    .total_drive       (out_ch.total_drive),
    .proportional_term (out_ch.proportional_term),
    .integral_term     (out_ch.integral_term),
    .derivative_term   (out_ch.derivative_term)
  );

endmodule
